// ===== src/ncm_pkg.sv =====
// Shared types and constants for the nearest reference colour matcher.
`default_nettype none
package ncm_pkg;

    // field widths fixed by the interface
    localparam int CHAN_W     = 8;
    localparam int RGB_W      = 3 * CHAN_W;
    localparam int DIST_W     = 10;
    localparam int OUT_IDX_W  = 4;
    localparam int SLOT_W     = 4;
    localparam int CFG_W      = 5;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // sum of three squared 8-bit differences fits in 18 bits
    localparam int SUM_W      = 18;
    localparam int STEP_W     = 4;

    // distance unit step codes: three accumulate steps, then nine root steps
    localparam logic [STEP_W-1:0] STEP_ACC_LAST  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_ROOT_LAST = 4'd11;
    // first trial bit of the root: 4^8
    localparam logic [SUM_W-1:0]  ROOT_BIT_FIRST = 18'h10000;

    localparam logic [DIST_W-1:0] NOT_FOUND_DIST = 10'd765;
    localparam logic [DIST_W-1:0] MAX_MATCH_DIST = 10'd441;

    // word kinds on the input stream
    localparam logic KIND_LOAD     = 1'b0;
    localparam logic KIND_CLASSIFY = 1'b1;

    // register index decoded from paddr[2]
    localparam logic REG_COLORS_IN_USE = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_START,
        S_WAIT,
        S_RESULT
    } t_state;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] distance;
    } t_dist_res;

endpackage
`default_nettype wire

// ===== src/ncm_table.sv =====
// Reference colour memory: one write port, one registered read port.
`default_nettype none
module ncm_table
    import ncm_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int IDX_W = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [IDX_W-1:0] i_wr_addr,
    input  wire logic [RGB_W-1:0] i_wr_data,
    input  wire logic [IDX_W-1:0] i_rd_addr,
    output logic      [RGB_W-1:0] o_rd_data
);

    logic [RGB_W-1:0] r_mem [DEPTH];
    logic [RGB_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ===== src/ncm_dist.sv =====
// Iterative distance unit: squared channel differences, then bitwise floor root.
`default_nettype none
module ncm_dist
    import ncm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [RGB_W-1:0] i_sample,
    input  wire logic [RGB_W-1:0] i_entry,
    output t_dist_res             o_res
);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [RGB_W-1:0]  r_sample;
    logic [RGB_W-1:0]  r_entry;
    logic [SUM_W-1:0]  r_rem;
    logic [SUM_W-1:0]  r_root;
    logic [SUM_W-1:0]  r_bit;

    logic [CHAN_W-1:0]   a_chan;
    logic [CHAN_W-1:0]   b_chan;
    logic [CHAN_W-1:0]   diff;
    logic [2*CHAN_W-1:0] sq;
    logic [SUM_W-1:0]    acc_sum;
    logic [SUM_W-1:0]    trial;
    logic                take;
    logic                acc_phase;

    // channel select and squared difference (red, green, blue in turn)
    always_comb begin
        case (r_step[1:0])
            2'd0:    begin a_chan = r_sample[CHAN_W-1:0];
                           b_chan = r_entry[CHAN_W-1:0]; end
            2'd1:    begin a_chan = r_sample[2*CHAN_W-1:CHAN_W];
                           b_chan = r_entry[2*CHAN_W-1:CHAN_W]; end
            default: begin a_chan = r_sample[RGB_W-1:2*CHAN_W];
                           b_chan = r_entry[RGB_W-1:2*CHAN_W]; end
        endcase
        diff      = (a_chan >= b_chan) ? (a_chan - b_chan) : (b_chan - a_chan);
        sq        = diff * diff;
        acc_sum   = ((r_step == '0) ? '0 : r_rem) + SUM_W'(sq);
        trial     = r_root + r_bit;
        take      = (r_rem >= trial);
        acc_phase = (r_step <= STEP_ACC_LAST);
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_ROOT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: accumulate, then one root digit a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sample <= i_sample;
            r_entry  <= i_entry;
        end else if (r_busy) begin
            if (acc_phase) begin
                r_rem <= acc_sum;
                if (r_step == STEP_ACC_LAST) begin
                    r_root <= '0;
                    r_bit  <= ROOT_BIT_FIRST;
                end
            end else begin
                if (take) begin
                    r_rem  <= r_rem - trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
            end
        end
    end

    assign o_res.done     = r_done;
    assign o_res.distance = r_root[DIST_W-1:0];

endmodule
`default_nettype wire

// ===== src/nearest_rgb_color_match_core.sv =====
// Nearest reference colour matcher: top level with sequencer and register port.
// A load word gives no result and leaves the block ready for the next word.
// A classify word walks colors_in_use entries (capped at TABLE_DEPTH) in turn: table read,
// start, the accumulate and root steps of the shared distance unit, then compare; the result
// follows the last entry, and colors_in_use of zero gives the result the next cycle.
// Synchronous active-low reset clears control and colors_in_use; table stays unset.
`default_nettype none
module nearest_rgb_color_match_core
    import ncm_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // input words
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // [3:0] entry_index, [11:4] red, [19:12] green, [27:20] blue, [31:28] zero
    input  wire logic [31:0]           s_axis_tdata,
    // [0] kind
    input  wire logic                  s_axis_tuser,
    // result words
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [3:0] best_index, [13:4] best_distance, [15:14] zero
    output logic [15:0]                m_axis_tdata,
    // [0] found
    output logic                       m_axis_tuser,
    // register port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_RAW = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W   = (CNT_RAW > CFG_W) ? CNT_RAW : CFG_W;
    localparam int CMP_W   = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

    t_state            r_state;
    t_state            n_state;
    logic [CFG_W-1:0]  r_colors;
    logic [CNT_W-1:0]  r_count;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_best_idx;
    logic [DIST_W-1:0] r_best_dist;
    logic              r_found;
    logic [RGB_W-1:0]  r_sample;

    logic              in_acc;
    logic              out_acc;
    logic              cfg_wr;
    logic              is_classify;
    logic              slot_ok;
    logic              tbl_wr;
    logic [RGB_W-1:0]  in_rgb;
    logic [RGB_W-1:0]  entry_rgb;
    logic [CNT_W-1:0]  colors_w;
    logic [CNT_W-1:0]  count_sat;
    logic              last_entry;
    logic              dist_start;
    t_dist_res         dist_res;

    assign in_acc      = s_axis_tvalid && s_axis_tready;
    assign out_acc     = m_axis_tvalid && m_axis_tready;
    assign is_classify = (s_axis_tuser == KIND_CLASSIFY);
    assign in_rgb      = s_axis_tdata[SLOT_W+RGB_W-1:SLOT_W];
    assign slot_ok     = (CMP_W'(s_axis_tdata[SLOT_W-1:0]) < CMP_W'(TABLE_DEPTH));
    assign tbl_wr      = in_acc && (s_axis_tuser == KIND_LOAD) && slot_ok;
    assign colors_w    = CNT_W'(r_colors);
    assign count_sat   = (colors_w > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : colors_w;
    assign last_entry  = ((CNT_W'(r_idx) + CNT_W'(1)) == r_count);

    // register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_COLORS_IN_USE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colors <= '0;
        end else if (cfg_wr) begin
            r_colors <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_COLORS_IN_USE) begin
            prdata = APB_DATA_W'(r_colors);
        end
    end

    // reference table
    ncm_table #(
        .DEPTH (TABLE_DEPTH),
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (tbl_wr),
        .i_wr_addr (IDX_W'(s_axis_tdata[SLOT_W-1:0])),
        .i_wr_data (in_rgb),
        .i_rd_addr (r_idx),
        .o_rd_data (entry_rgb)
    );

    // shared distance unit
    ncm_dist u_dist (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (dist_start),
        .i_sample (r_sample),
        .i_entry  (entry_rgb),
        .o_res    (dist_res)
    );

    // sequencer: next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && is_classify) begin
                    n_state = (count_sat == '0) ? S_RESULT : S_FETCH;
                end
            end
            S_FETCH:  n_state = S_START;
            S_START:  n_state = S_WAIT;
            S_WAIT: begin
                if (dist_res.done) begin
                    n_state = last_entry ? S_RESULT : S_FETCH;
                end
            end
            S_RESULT: begin
                if (out_acc) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // sequencer: outputs
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        dist_start    = 1'b0;
        case (r_state)
            S_IDLE:   s_axis_tready = 1'b1;
            S_START:  dist_start    = 1'b1;
            S_RESULT: m_axis_tvalid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // search bookkeeping
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc && is_classify) begin
            r_sample    <= in_rgb;
            r_count     <= count_sat;
            r_idx       <= '0;
            r_best_idx  <= '0;
            r_best_dist <= NOT_FOUND_DIST;
            r_found     <= 1'b0;
        end else if (r_state == S_WAIT && dist_res.done) begin
            // strict compare keeps the lowest index on ties
            if (dist_res.distance < r_best_dist) begin
                r_best_dist <= dist_res.distance;
                r_best_idx  <= r_idx;
                r_found     <= 1'b1;
            end
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    assign m_axis_tuser = r_found;
    assign m_axis_tdata = {2'b00, r_best_dist, OUT_IDX_W'(r_best_idx)};

endmodule
`default_nettype wire

// ===== src/ncm_checker.sv =====
// Port-level checks for the nearest reference colour matcher, bound to the top level.
`default_nettype none
module ncm_checker
    import ncm_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [31:0]           s_axis_tdata,
    input  wire logic                  s_axis_tuser,
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [15:0]           m_axis_tdata,
    input  wire logic                  m_axis_tuser,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    input  wire logic [APB_DATA_W-1:0] prdata,
    input  wire logic                  pready
);

    // one word at a time: never ready for input while a result waits
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while a result is pending");

    // a load gives no result and leaves the block ready
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_LOAD)
        |=> (s_axis_tready && !m_axis_tvalid))
        else $error("load word produced a result or stalled");

    // a classify word makes the block busy
    a_classify_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == KIND_CLASSIFY)
        |=> !s_axis_tready)
        else $error("classify word did not start a search");

    // result fields are consistent with the found flag
    a_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser ? (m_axis_tdata[13:4] <= MAX_MATCH_DIST)
                                        : (m_axis_tdata[13:4] == NOT_FOUND_DIST &&
                                           m_axis_tdata[3:0] == 4'd0)))
        else $error("result distance or index inconsistent with found");

    // a stalled result holds
    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready)
        |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

endmodule

bind nearest_rgb_color_match_core ncm_checker u_ncm_checker (.*);
`default_nettype wire
